/* hdl/method_descriptor_validator_macros.svh */
// ---------------------------------------------------------------------------
// method descriptor validator assertion macros
// shared concurrent assertion forms, sampled on clock, disabled in reset
// ---------------------------------------------------------------------------
`ifndef METHOD_DESCRIPTOR_VALIDATOR_MACROS_SVH
`define METHOD_DESCRIPTOR_VALIDATOR_MACROS_SVH

// condition holds at every edge
`define MDV_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MDV_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define MDV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/mdv_pkg.sv */
// ---------------------------------------------------------------------------
// mdv_pkg
// character codes, error codes and result types of the method descriptor
// validator
// ---------------------------------------------------------------------------
`default_nettype none

package mdv_pkg;

   localparam logic [7:0] CH_OPEN  = 8'h28; // (
   localparam logic [7:0] CH_CLOSE = 8'h29; // )
   localparam logic [7:0] CH_ARRAY = 8'h5B; // [
   localparam logic [7:0] CH_CLASS = 8'h4C; // L
   localparam logic [7:0] CH_SEMI  = 8'h3B; // ;
   localparam logic [7:0] CH_SLASH = 8'h2F; // /
   localparam logic [7:0] CH_DOT   = 8'h2E; // .
   localparam logic [7:0] CH_VOID  = 8'h56; // V
   localparam logic [7:0] CH_LONG  = 8'h4A; // J
   localparam logic [7:0] CH_DBL   = 8'h44; // D
   localparam logic [7:0] CH_BOOL  = 8'h5A; // Z
   localparam logic [7:0] CH_BYTE  = 8'h42; // B
   localparam logic [7:0] CH_CHAR  = 8'h43; // C
   localparam logic [7:0] CH_SHORT = 8'h53; // S
   localparam logic [7:0] CH_INT   = 8'h49; // I
   localparam logic [7:0] CH_FLOAT = 8'h46; // F

   typedef logic [3:0] err_type;

   localparam err_type ERR_NONE       = 4'd0;
   localparam err_type ERR_OPEN_PAREN = 4'd1;
   localparam err_type ERR_DIMS       = 4'd2;
   localparam err_type ERR_EARLY_END  = 4'd3;
   localparam err_type ERR_TERMINATOR = 4'd4;
   localparam err_type ERR_CLASS_NAME = 4'd5;
   localparam err_type ERR_MARKER     = 4'd6;
   localparam err_type ERR_VOID       = 4'd7;
   localparam err_type ERR_SLOTS      = 4'd8;
   localparam err_type ERR_CLOSE      = 4'd9;
   localparam err_type ERR_NO_RESULT  = 4'd10;
   localparam err_type ERR_TRAILING   = 4'd11;

   typedef enum logic [1:0] {
      NS_EMPTY = 2'd0,
      NS_OK    = 2'd1,
      NS_SLASH = 2'd2,
      NS_BAD   = 2'd3
   } name_scan_type;

   localparam logic [7:0] PARAMS_SAT = 8'hFF;

   typedef struct packed {
      err_type     error_code;
      logic [15:0] error_offset;
      logic        type_done;
      logic        type_is_return;
      logic        type_is_array;
      logic        type_is_primitive;
      logic [1:0]  type_slots;
      logic [7:0]  param_count;
      logic [7:0]  slots_total;
      logic        accepted;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/method_descriptor_validator.sv */
// one request per cycle while req_stall is low; each response is registered before output
// parse state and the response are computed in a single pass from the state registers
// a skid entry behind the output register takes one more request while rsp_stall is high,
// then req_stall rises until the skid entry has moved to the output register
// synchronous active-high reset returns to expecting the open paren, no responses pending
// the final byte of each descriptor also returns the parser to its reset state
// ---------------------------------------------------------------------------
// method_descriptor_validator
// streaming checker for method type descriptors, one byte per request,
// reporting each completed type token, the first error and acceptance
// ---------------------------------------------------------------------------
`default_nettype none

`include "method_descriptor_validator_macros.svh"

module method_descriptor_validator
   import mdv_pkg::*;
#(
   parameter int MAX_ARRAY_DIMS  = 255,
   parameter int MAX_PARAM_SLOTS = 255,
   parameter int MAX_LENGTH      = 65535
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_error_code,
   output logic [15:0]      rsp_error_offset,
   output logic             rsp_type_done,
   output logic             rsp_type_is_return,
   output logic             rsp_type_is_array,
   output logic             rsp_type_is_primitive,
   output logic [1:0]       rsp_type_slots,
   output logic [7:0]       rsp_param_count,
   output logic [7:0]       rsp_slots_total,
   output logic             rsp_accepted
);

   localparam logic [8:0]  MaxDims  = 9'(MAX_ARRAY_DIMS);
   localparam logic [9:0]  MaxSlots = 10'(MAX_PARAM_SLOTS);
   localparam logic [16:0] MaxLen17 = 17'(MAX_LENGTH);
   localparam logic [15:0] MaxLen   = 16'(MAX_LENGTH);

   typedef enum logic [2:0] {
      PH_OPEN   = 3'd0,
      PH_PARAM  = 3'd1,
      PH_PNAME  = 3'd2,
      PH_RESULT = 3'd3,
      PH_RNAME  = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [8:0]    dim_ff, dim_in;
   logic [8:0]    slot_sum_ff, slot_sum_in;
   logic [15:0]   pos_ff, pos_in;
   logic [15:0]   tok_ff, tok_in;
   logic [15:0]   name_start_ff, name_start_in;
   name_scan_type scan_ff, scan_in;
   logic [7:0]    params_ff, params_in;
   err_type       err_ff, err_in;
   logic [15:0]   err_pos_ff, err_pos_in;

   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   logic          skid_full_ff;
   rsp_type       skid_ff;

   logic          req_accept;
   logic          rsp_open;
   rsp_type       rsp_in;

   logic [16:0]   pos_inc;
   logic [15:0]   nxt;
   logic [15:0]   tok_eff;
   logic          is_ret;
   logic          is_prim;
   logic [8:0]    dim_inc;
   logic [9:0]    slot_add;

   err_type       raise_code;
   logic [15:0]   raise_off;
   logic          fin_req;
   logic          fin_ret;
   logic          fin_prim;
   logic [1:0]    fin_slots;
   logic          fin_ok;
   logic          o_done;
   logic          o_ret;
   logic          o_arr;
   logic          o_prim;
   logic [1:0]    o_slots;
   err_type       err_new;
   logic [15:0]   err_pos_new;

   assign req_accept = req_valid && !skid_full_ff;
   assign req_stall  = skid_full_ff;
   assign rsp_open   = !rsp_valid_ff || !rsp_stall;

   assign pos_inc = {1'b0, pos_ff} + 17'd1;
   assign nxt     = (pos_inc > MaxLen17) ? MaxLen : pos_inc[15:0];
   assign tok_eff = (dim_ff == 9'd0) ? pos_ff : tok_ff;
   assign dim_inc = dim_ff + 9'd1;

   always_comb begin
      case (req_char_in) inside
         CH_BOOL, CH_BYTE, CH_CHAR, CH_SHORT, CH_INT,
         CH_LONG, CH_FLOAT, CH_DBL, CH_VOID: is_prim = 1'b1;
         default:                            is_prim = 1'b0;
      endcase
   end

   // byte decode
   always_comb begin
      phase_in      = phase_ff;
      dim_in        = dim_ff;
      tok_in        = tok_ff;
      name_start_in = name_start_ff;
      scan_in       = scan_ff;
      raise_code    = ERR_NONE;
      raise_off     = 16'd0;
      fin_req       = 1'b0;
      fin_ret       = 1'b0;
      fin_prim      = 1'b0;
      fin_slots     = 2'd0;
      is_ret        = (phase_ff == PH_RESULT) || (phase_ff == PH_RNAME);

      if (err_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_OPEN: begin
               if (req_char_in != CH_OPEN) begin
                  raise_code = ERR_OPEN_PAREN;
                  raise_off  = pos_ff;
               end else begin
                  phase_in = PH_PARAM;
                  if (req_last) begin
                     raise_code = ERR_CLOSE;
                     raise_off  = nxt;
                  end
               end
            end
            PH_PARAM, PH_RESULT: begin
               if (!is_ret && req_char_in == CH_CLOSE && dim_ff == 9'd0) begin
                  phase_in = PH_RESULT;
                  if (req_last) begin
                     raise_code = ERR_NO_RESULT;
                     raise_off  = nxt;
                  end
               end else if (req_char_in == CH_ARRAY) begin
                  tok_in = tok_eff;
                  dim_in = dim_inc;
                  if (dim_inc > MaxDims) begin
                     raise_code = ERR_DIMS;
                     raise_off  = tok_eff;
                  end else if (req_last) begin
                     raise_code = ERR_EARLY_END;
                     raise_off  = nxt;
                  end
               end else if (req_char_in == CH_CLASS) begin
                  tok_in        = tok_eff;
                  name_start_in = nxt;
                  scan_in       = NS_EMPTY;
                  phase_in      = is_ret ? PH_RNAME : PH_PNAME;
                  if (req_last) begin
                     raise_code = ERR_TERMINATOR;
                     raise_off  = nxt;
                  end
               end else if (is_prim) begin
                  tok_in = tok_eff;
                  if (req_char_in == CH_VOID && (!is_ret || dim_ff != 9'd0)) begin
                     raise_code = ERR_VOID;
                     raise_off  = tok_eff;
                  end else begin
                     fin_req  = 1'b1;
                     fin_ret  = is_ret;
                     fin_prim = (dim_ff == 9'd0);
                     if (dim_ff == 9'd0 && (req_char_in == CH_LONG || req_char_in == CH_DBL)) begin
                        fin_slots = 2'd2;
                     end else if (req_char_in == CH_VOID) begin
                        fin_slots = 2'd0;
                     end else begin
                        fin_slots = 2'd1;
                     end
                  end
               end else begin
                  raise_code = ERR_MARKER;
                  raise_off  = pos_ff;
               end
            end
            PH_PNAME, PH_RNAME: begin
               if (req_char_in == CH_SEMI) begin
                  if (scan_ff == NS_OK) begin
                     fin_req   = 1'b1;
                     fin_ret   = is_ret;
                     fin_prim  = 1'b0;
                     fin_slots = 2'd1;
                  end else begin
                     raise_code = ERR_CLASS_NAME;
                     raise_off  = name_start_ff;
                  end
               end else begin
                  if (scan_ff != NS_BAD) begin
                     if (req_char_in == CH_SLASH) begin
                        scan_in = (scan_ff == NS_OK) ? NS_SLASH : NS_BAD;
                     end else if (req_char_in == CH_DOT || req_char_in == CH_ARRAY ||
                                  req_char_in == CH_OPEN || req_char_in == CH_CLOSE) begin
                        scan_in = NS_BAD;
                     end else begin
                        scan_in = NS_OK;
                     end
                  end
                  if (req_last) begin
                     raise_code = ERR_TERMINATOR;
                     raise_off  = name_start_ff;
                  end
               end
            end
            default: begin
               raise_code = ERR_TRAILING;
               raise_off  = pos_ff;
            end
         endcase
      end
   end

   // token completion
   assign slot_add = {1'b0, slot_sum_ff} + {8'd0, fin_slots};

   always_comb begin
      slot_sum_in = slot_sum_ff;
      params_in   = params_ff;
      fin_ok      = 1'b0;
      o_done      = 1'b0;
      o_ret       = 1'b0;
      o_arr       = 1'b0;
      o_prim      = 1'b0;
      o_slots     = 2'd0;
      err_new     = err_ff;
      err_pos_new = err_pos_ff;

      if (raise_code != ERR_NONE) begin
         err_new     = raise_code;
         err_pos_new = raise_off;
      end

      if (fin_req) begin
         if (!fin_ret && slot_add > MaxSlots) begin
            err_new     = ERR_SLOTS;
            err_pos_new = nxt;
         end else begin
            fin_ok = 1'b1;
            if (!fin_ret) begin
               slot_sum_in = slot_add[8:0];
               if (params_ff != PARAMS_SAT) begin
                  params_in = params_ff + 8'd1;
               end
               if (req_last) begin
                  err_new     = ERR_CLOSE;
                  err_pos_new = nxt;
               end
            end
            o_done  = 1'b1;
            o_ret   = fin_ret;
            o_arr   = (dim_ff != 9'd0);
            o_prim  = fin_prim;
            o_slots = fin_slots;
         end
      end
   end

   always_comb begin
      rsp_in.error_code        = err_new;
      rsp_in.error_offset      = err_pos_new;
      rsp_in.type_done         = o_done;
      rsp_in.type_is_return    = o_ret;
      rsp_in.type_is_array     = o_arr;
      rsp_in.type_is_primitive = o_prim;
      rsp_in.type_slots        = o_slots;
      rsp_in.param_count       = params_in;
      rsp_in.slots_total       = slot_sum_in[7:0];
      rsp_in.accepted          = req_last && (err_new == ERR_NONE) &&
                                 (fin_ok ? fin_ret : (phase_in == PH_DONE));
      pos_in     = nxt;
      err_in     = err_new;
      err_pos_in = err_pos_new;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_OPEN;
         dim_ff        <= 9'd0;
         slot_sum_ff   <= 9'd0;
         pos_ff        <= 16'd0;
         tok_ff        <= 16'd0;
         name_start_ff <= 16'd0;
         scan_ff       <= NS_EMPTY;
         params_ff     <= 8'd0;
         err_ff        <= ERR_NONE;
         err_pos_ff    <= 16'd0;
      end else if (req_accept) begin
         if (req_last) begin
            phase_ff      <= PH_OPEN;
            dim_ff        <= 9'd0;
            slot_sum_ff   <= 9'd0;
            pos_ff        <= 16'd0;
            tok_ff        <= 16'd0;
            name_start_ff <= 16'd0;
            scan_ff       <= NS_EMPTY;
            params_ff     <= 8'd0;
            err_ff        <= ERR_NONE;
            err_pos_ff    <= 16'd0;
         end else begin
            phase_ff      <= fin_ok ? (fin_ret ? PH_DONE : PH_PARAM) : phase_in;
            dim_ff        <= fin_ok ? 9'd0 : dim_in;
            slot_sum_ff   <= slot_sum_in;
            pos_ff        <= pos_in;
            tok_ff        <= tok_in;
            name_start_ff <= name_start_in;
            scan_ff       <= scan_in;
            params_ff     <= params_in;
            err_ff        <= err_in;
            err_pos_ff    <= err_pos_in;
         end
      end
   end

   // response register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (rsp_open) begin
         if (skid_full_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_open) begin
         if (skid_full_ff) begin
            rsp_ff <= skid_ff;
         end else if (req_accept) begin
            rsp_ff <= rsp_in;
         end
      end else if (req_accept) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_error_code        = rsp_ff.error_code;
   assign rsp_error_offset      = rsp_ff.error_offset;
   assign rsp_type_done         = rsp_ff.type_done;
   assign rsp_type_is_return    = rsp_ff.type_is_return;
   assign rsp_type_is_array     = rsp_ff.type_is_array;
   assign rsp_type_is_primitive = rsp_ff.type_is_primitive;
   assign rsp_type_slots        = rsp_ff.type_slots;
   assign rsp_param_count       = rsp_ff.param_count;
   assign rsp_slots_total       = rsp_ff.slots_total;
   assign rsp_accepted          = rsp_ff.accepted;

   `MDV_ASSERT_IMPLIES(a_skid_behind_rsp, skid_full_ff, rsp_valid_ff, "skid full with output empty")
   `MDV_ASSERT_IMPLIES(a_accept_clean, rsp_valid_ff && rsp_ff.accepted, rsp_ff.error_code == ERR_NONE, "accepted with error")
   `MDV_ASSERT_NEXT(a_err_sticky, req_accept && !req_last && err_ff != ERR_NONE, err_ff == $past(err_ff) && err_pos_ff == $past(err_pos_ff), "error not sticky")

endmodule

`default_nettype wire

/* tb/method_descriptor_validator_tb.sv */
// ---------------------------------------------------------------------------
// method_descriptor_validator_tb
// streams method descriptors into the validator one byte per request with
// bursty requests and a wandering response stall, predicts every response
// from a behavioural copy of the parser and compares it field by field
// ---------------------------------------------------------------------------
`default_nettype none

module method_descriptor_validator_tb
   import mdv_pkg::*;
();

   localparam int unsigned DIM_LIMIT    = 255;
   localparam int unsigned SLOT_LIMIT   = 255;
   localparam int unsigned OFFSET_LIMIT = 65535;

   typedef enum logic [2:0] {
      AT_OPEN, AT_PARAM, AT_PNAME, AT_RESULT, AT_RNAME, AT_DONE
   } parse_phase_type;

   typedef struct packed {
      logic       pause;
      logic       last;
      logic [7:0] ch;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_error_code;
   logic [15:0] rsp_error_offset;
   logic        rsp_type_done;
   logic        rsp_type_is_return;
   logic        rsp_type_is_array;
   logic        rsp_type_is_primitive;
   logic [1:0]  rsp_type_slots;
   logic [7:0]  rsp_param_count;
   logic [7:0]  rsp_slots_total;
   logic        rsp_accepted;

   stim_type      stimulus[$];
   logic [7:0]    draft[$];
   rsp_type       due_verdicts[$];
   stim_type      head_item;
   int unsigned   burst_left = 8;
   int unsigned   gap_left = 0;
   int unsigned   cycle_no = 0;
   int unsigned   hold_left = 0;
   int unsigned   style = 0;
   int unsigned   style_left = 0;
   bit            failed = 1'b0;

   // parser state
   parse_phase_type phase_q;
   logic [8:0]    dims_q;
   logic [8:0]    slots_q;
   int unsigned   pos_q;
   int unsigned   tok_q;
   int unsigned   name_q;
   name_scan_type scan_q;
   logic [7:0]    params_q;
   err_type       err_q;
   logic [15:0]   err_at_q;

   method_descriptor_validator dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_char_in           (req_char_in),
      .req_last              (req_last),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_error_code        (rsp_error_code),
      .rsp_error_offset      (rsp_error_offset),
      .rsp_type_done         (rsp_type_done),
      .rsp_type_is_return    (rsp_type_is_return),
      .rsp_type_is_array     (rsp_type_is_array),
      .rsp_type_is_primitive (rsp_type_is_primitive),
      .rsp_type_slots        (rsp_type_slots),
      .rsp_param_count       (rsp_param_count),
      .rsp_slots_total       (rsp_slots_total),
      .rsp_accepted          (rsp_accepted)
   );

   always #4 clock = ~clock;

   task automatic clear_parse();
      phase_q  = AT_OPEN;
      dims_q   = '0;
      slots_q  = '0;
      pos_q    = 0;
      tok_q    = 0;
      name_q   = 0;
      scan_q   = NS_EMPTY;
      params_q = '0;
      err_q    = ERR_NONE;
      err_at_q = '0;
   endtask

   task automatic raise_fault(input err_type code, input int unsigned off);
      if (err_q == ERR_NONE) begin
         err_q    = code;
         err_at_q = off[15:0];
      end
   endtask

   task automatic complete_token(input logic is_ret, input logic prim, input logic [1:0] slots,
                                 input logic last, input int unsigned nxt,
                                 inout rsp_type r);
      int unsigned sum;
      if (!is_ret) begin
         sum = slots_q + slots;
         // overflowing token is neither reported nor counted
         if (sum > SLOT_LIMIT) begin
            raise_fault(ERR_SLOTS, nxt);
            return;
         end
         slots_q = sum[8:0];
         if (params_q != PARAMS_SAT) params_q++;
      end
      r.type_done         = 1'b1;
      r.type_is_return    = is_ret;
      r.type_is_array     = (dims_q != 0);
      r.type_is_primitive = prim;
      r.type_slots        = slots;
      dims_q = '0;
      if (is_ret) begin
         phase_q = AT_DONE;
      end else begin
         phase_q = AT_PARAM;
         if (last) raise_fault(ERR_CLOSE, nxt);
      end
   endtask

   task automatic descriptor_step(input logic [7:0] c, input logic last, output rsp_type r);
      int unsigned pos;
      int unsigned nxt;
      logic        is_ret;
      logic        is_prim;
      logic [1:0]  slots;
      r   = '0;
      pos = pos_q;
      nxt = (pos_q + 1 > OFFSET_LIMIT) ? OFFSET_LIMIT : pos_q + 1;
      is_prim = c == CH_BOOL || c == CH_BYTE || c == CH_CHAR || c == CH_SHORT ||
                c == CH_INT || c == CH_LONG || c == CH_FLOAT || c == CH_DBL || c == CH_VOID;
      if (err_q == ERR_NONE) begin
         case (phase_q)
            AT_OPEN: begin
               if (c != CH_OPEN) begin
                  raise_fault(ERR_OPEN_PAREN, pos);
               end else begin
                  phase_q = AT_PARAM;
                  if (last) raise_fault(ERR_CLOSE, nxt);
               end
            end
            AT_PARAM, AT_RESULT: begin
               is_ret = (phase_q == AT_RESULT);
               if (!is_ret && c == CH_CLOSE && dims_q == 0) begin
                  phase_q = AT_RESULT;
                  if (last) raise_fault(ERR_NO_RESULT, nxt);
               end else if (c == CH_ARRAY) begin
                  if (dims_q == 0) tok_q = pos;
                  dims_q++;
                  if (dims_q > DIM_LIMIT) raise_fault(ERR_DIMS, tok_q);
                  else if (last) raise_fault(ERR_EARLY_END, nxt);
               end else if (c == CH_CLASS) begin
                  if (dims_q == 0) tok_q = pos;
                  name_q  = nxt;
                  scan_q  = NS_EMPTY;
                  phase_q = is_ret ? AT_RNAME : AT_PNAME;
                  if (last) raise_fault(ERR_TERMINATOR, name_q);
               end else if (is_prim) begin
                  if (dims_q == 0) tok_q = pos;
                  if (c == CH_VOID && (!is_ret || dims_q != 0)) begin
                     raise_fault(ERR_VOID, tok_q);
                  end else begin
                     slots = 2'd1;
                     if (dims_q == 0 && (c == CH_LONG || c == CH_DBL)) slots = 2'd2;
                     else if (c == CH_VOID) slots = 2'd0;
                     complete_token(is_ret, dims_q == 0, slots, last, nxt, r);
                  end
               end else begin
                  raise_fault(ERR_MARKER, pos);
               end
            end
            AT_PNAME, AT_RNAME: begin
               is_ret = (phase_q == AT_RNAME);
               if (c == CH_SEMI) begin
                  if (scan_q == NS_OK) complete_token(is_ret, 1'b0, 2'd1, last, nxt, r);
                  else raise_fault(ERR_CLASS_NAME, name_q);
               end else begin
                  if (scan_q != NS_BAD) begin
                     if (c == CH_SLASH)
                        scan_q = (scan_q == NS_OK) ? NS_SLASH : NS_BAD;
                     else if (c == CH_DOT || c == CH_ARRAY || c == CH_OPEN || c == CH_CLOSE)
                        scan_q = NS_BAD;
                     else
                        scan_q = NS_OK;
                  end
                  if (last) raise_fault(ERR_TERMINATOR, name_q);
               end
            end
            default: raise_fault(ERR_TRAILING, pos);
         endcase
      end
      pos_q = nxt;
      r.error_code   = err_q;
      r.error_offset = err_at_q;
      r.param_count  = params_q;
      r.slots_total  = slots_q[7:0];
      r.accepted     = last && err_q == ERR_NONE && phase_q == AT_DONE;
      if (last) clear_parse();
   endtask

   // stimulus building

   function automatic logic [7:0] pick_marker(input int unsigned sel);
      case (sel)
         0:       return CH_BOOL;
         1:       return CH_BYTE;
         2:       return CH_CHAR;
         3:       return CH_SHORT;
         4:       return CH_INT;
         5:       return CH_FLOAT;
         6:       return CH_LONG;
         7:       return CH_DBL;
         8:       return CH_VOID;
         9:       return CH_OPEN;
         10:      return CH_CLOSE;
         11:      return CH_ARRAY;
         12:      return CH_CLASS;
         13:      return CH_SEMI;
         14:      return CH_SLASH;
         default: return CH_DOT;
      endcase
   endfunction

   task automatic commit_draft();
      int unsigned k;
      for (k = 0; k < draft.size(); k++)
         stimulus.push_back({1'b0, k == draft.size() - 1, draft[k]});
      draft.delete();
   endtask

   task automatic push_text(input string s);
      int unsigned k;
      for (k = 0; k < s.len(); k++) draft.push_back(s[k]);
      commit_draft();
   endtask

   task automatic add_type(input logic as_result);
      int unsigned dims;
      int unsigned oddity;
      int unsigned segs;
      int unsigned seg_len;
      int unsigned s;
      int unsigned k;
      dims = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      for (k = 0; k < dims; k++) draft.push_back(CH_ARRAY);
      if (as_result && $urandom_range(0, 3) == 0) begin
         draft.push_back(CH_VOID);
      end else if ($urandom_range(0, 3) == 0) begin
         draft.push_back(CH_CLASS);
         oddity = $urandom_range(0, 15);
         if (oddity == 1) draft.push_back(CH_SLASH);
         if (oddity != 0) begin
            segs = $urandom_range(1, 3);
            for (s = 0; s < segs; s++) begin
               if (s != 0) begin
                  draft.push_back(CH_SLASH);
                  if (oddity == 3) draft.push_back(CH_SLASH);
               end
               seg_len = $urandom_range(1, 4);
               for (k = 0; k < seg_len; k++) begin
                  if (oddity == 4 && k == 0 && s == segs - 1)
                     draft.push_back(pick_marker($urandom_range(0, 3) == 0 ? 15 :
                                                 $urandom_range(9, 11)));
                  else if ($urandom_range(0, 9) == 0)
                     draft.push_back(8'(8'h30 + $urandom_range(0, 9)));
                  else
                     draft.push_back(8'(8'h61 + $urandom_range(0, 25)));
               end
            end
            if (oddity == 2) draft.push_back(CH_SLASH);
         end
         draft.push_back(CH_SEMI);
      end else begin
         draft.push_back(pick_marker($urandom_range(0, 7)));
      end
   endtask

   task automatic add_random_descriptor();
      int unsigned n;
      int unsigned k;
      int unsigned at;
      if ($urandom_range(0, 99) < 15) begin
         // line noise, sometimes with a plausible opening
         n = $urandom_range(1, 6);
         for (k = 0; k < n; k++) begin
            if (k == 0 && $urandom_range(0, 1) == 0) draft.push_back(CH_OPEN);
            else if ($urandom_range(0, 1) == 0) draft.push_back(8'($urandom_range(0, 255)));
            else draft.push_back(pick_marker($urandom_range(0, 15)));
         end
      end else begin
         draft.push_back(CH_OPEN);
         n = $urandom_range(0, 5);
         for (k = 0; k < n; k++) add_type(1'b0);
         draft.push_back(CH_CLOSE);
         add_type(1'b1);
         if ($urandom_range(0, 99) < 40) begin
            at = $urandom_range(0, draft.size() - 1);
            case ($urandom_range(0, 4))
               0: draft[at] = 8'($urandom_range(0, 255));
               1: draft[at] = pick_marker($urandom_range(0, 15));
               2: while (draft.size() > at + 1) draft.pop_back();
               3: begin
                  n = $urandom_range(1, 3);
                  for (k = 0; k < n; k++) draft.push_back(8'($urandom_range(0, 255)));
               end
               default: draft.insert(at, pick_marker($urandom_range(0, 15)));
            endcase
         end
      end
      commit_draft();
   endtask

   // sender: bursts of requests with gaps, pause markers wait for the pipe to drain
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stimulus.size() == 0) begin
            req_valid <= 1'b0;
         end else if (stimulus[0].pause) begin
            req_valid <= 1'b0;
            if (!req_valid && due_verdicts.size() == 0) stimulus.delete(0);
         end else begin
            head_item = stimulus.pop_front();
            req_valid   <= 1'b1;
            req_char_in <= head_item.ch;
            req_last    <= head_item.last;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) :
                                                          $urandom_range(1, 12);
               gap_left   = $urandom_range(1, 7);
            end
         end
      end
   end

   // receiver: stall style changes now and then, with a long hold-off at intervals
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_no++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (cycle_no % 4000 == 400) begin
            hold_left = 63;
            rsp_stall <= 1'b1;
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 3);
               style_left = $urandom_range(16, 160);
            end else begin
               style_left--;
            end
            case (style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= (cycle_no % 5 < 2);
            endcase
         end
      end
   end

   task automatic compare_field(input string label, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         failed = 1'b1;
         $display("%0t: %s expected %0d got %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_parse();
      end else begin
         if (req_valid && !req_stall) begin
            descriptor_step(req_char_in, req_last, want);
            due_verdicts.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_verdicts.size() == 0) begin
               failed = 1'b1;
               $display("%0t: response with no request outstanding, error_code %0d",
                        $time, rsp_error_code);
            end else begin
               want = due_verdicts.pop_front();
               compare_field("error_code", want.error_code, rsp_error_code);
               compare_field("error_offset", want.error_offset, rsp_error_offset);
               compare_field("type_done", want.type_done, rsp_type_done);
               compare_field("type_is_return", want.type_is_return, rsp_type_is_return);
               compare_field("type_is_array", want.type_is_array, rsp_type_is_array);
               compare_field("type_is_primitive", want.type_is_primitive,
                             rsp_type_is_primitive);
               compare_field("type_slots", want.type_slots, rsp_type_slots);
               compare_field("param_count", want.param_count, rsp_param_count);
               compare_field("slots_total", want.slots_total, rsp_slots_total);
               compare_field("accepted", want.accepted, rsp_accepted);
            end
         end
      end
   end

   initial begin : sequencer
      int unsigned k;
      int unsigned mark;
      // every primitive, an array of a class, zero parameters, bad opening, void parameter
      push_text("(ZBCSIJFD[La/b;)V");
      push_text("()V");
      push_text("x");
      push_text("(V)V");
      stimulus.push_back({1'b1, 1'b0, 8'h00});

      mark = stimulus.size() + 150;
      while (stimulus.size() < mark) add_random_descriptor();
      stimulus.push_back({1'b1, 1'b0, 8'h00});

      // slot total filled exactly, then one parameter too many
      draft.push_back(CH_OPEN);
      for (k = 0; k < SLOT_LIMIT / 2; k++) draft.push_back(pick_marker($urandom_range(6, 7)));
      draft.push_back(pick_marker($urandom_range(0, 5)));
      draft.push_back(pick_marker($urandom_range(0, 7)));
      draft.push_back(CH_CLOSE);
      draft.push_back(CH_VOID);
      commit_draft();

      mark = stimulus.size() + 140;
      while (stimulus.size() < mark) add_random_descriptor();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (stimulus.size() != 0 || req_valid || due_verdicts.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);

      if (!failed && due_verdicts.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #80000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

/* method_descriptor_validator.f */
+incdir+hdl
hdl/mdv_pkg.sv
hdl/method_descriptor_validator.sv
tb/method_descriptor_validator_tb.sv
